/* rtl/tftp_server_transfer_engine_assert.svh */
// ----------------------------------------------------------------------------
// TFTP server transfer engine assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TFTP_SERVER_TRANSFER_ENGINE_ASSERT_SVH
`define TFTP_SERVER_TRANSFER_ENGINE_ASSERT_SVH

// Plain clocked property, disabled while reset is asserted (active low).
`define TSTE_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Same-cycle implication.
`define TSTE_ASSERT_IMPLY(lbl, clk_s, rst_s, cond, expr, msg) \
  `TSTE_ASSERT_CLK(lbl, clk_s, rst_s, (cond) |-> (expr), msg)

`endif

/* rtl/tste_pkg.sv */
// ----------------------------------------------------------------------------
// TFTP server transfer engine package
// Transaction types, protocol codes and constants shared by the engine.
// ----------------------------------------------------------------------------
package tste_pkg;

  localparam logic [15:0] BLOCK_BYTES  = 16'd512;
  localparam logic [15:0] SERVICE_PORT = 16'd69;

  // Reset values
  localparam logic [31:0] SERVER_IP_RST   = 32'hC0A8_0106;  // 192.168.1.6
  localparam logic [15:0] WRQ_TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] FIRST_PORT_RST  = 16'd2098;
  localparam logic [31:0] CLIENT_IP_RST   = 32'hC0A2_0174;  // 192.162.1.116

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_IP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_MAC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRQ_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT = 3'd4;

  typedef enum logic [1:0] {
    CMD_ARP_REQ   = 2'd0,
    CMD_ARP_REPLY = 2'd1,
    CMD_UDP       = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  typedef enum logic [15:0] {
    OP_RRQ   = 16'd1,
    OP_WRQ   = 16'd2,
    OP_DATA  = 16'd3,
    OP_ACK   = 16'd4,
    OP_ERROR = 16'd5,
    OP_OACK  = 16'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_ARP_REPLY = 2'd1,
    ACT_ACK       = 2'd2,
    ACT_DATA      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DONE_NONE     = 2'd0,
    DONE_UPLOAD   = 2'd1,
    DONE_DOWNLOAD = 2'd2
  } done_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'b001,
    ST_UPLOAD   = 3'b010,
    ST_DOWNLOAD = 3'b100
  } proto_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] target_ip;
    logic        header_ok;
    logic [15:0] tftp_opcode;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] block_number;
    logic [15:0] payload_length;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
  } tste_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] reply_block;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [31:0] buffer_address;
    logic [15:0] byte_count;
    logic        store_payload;
    logic [1:0]  transfer_done;
    logic [31:0] total_length;
    logic        state_error;
  } tste_out_t;

  // Configuration write toward the core
  typedef struct packed {
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } tste_cfg_t;

endpackage

/* rtl/tste_core.sv */
// ----------------------------------------------------------------------------
// TFTP server transfer engine core
// Holds configuration and session state and decides the reply for one
// transaction. The reply is combinational; state updates when step is high.
// ----------------------------------------------------------------------------
module tste_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tste_pkg::tste_cfg_t cfg,
  input  logic                step,
  input  tste_pkg::tste_in_t  item,
  output tste_pkg::tste_out_t res
);
  import tste_pkg::*;

  // Configuration
  logic [31:0] server_ip_r;
  logic [47:0] server_mac_r;
  logic [31:0] image_base_r;
  logic [15:0] wrq_timeout_r;
  logic [15:0] first_port_r;

  // Session state
  proto_state_t proto_state_r, proto_state_nxt;
  logic         session_lock_r, session_lock_nxt;
  logic [15:0]  expected_block_r, expected_block_nxt;
  logic [15:0]  client_port_r, client_port_nxt;
  logic [15:0]  session_port_r, session_port_nxt;
  logic [47:0]  client_mac_r, client_mac_nxt;
  logic [31:0]  client_ip_r, client_ip_nxt;
  logic [31:0]  store_pointer_r, store_pointer_nxt;
  logic [31:0]  file_length_r, file_length_nxt;
  logic [31:0]  read_pointer_r, read_pointer_nxt;
  logic [31:0]  bytes_remaining_r, bytes_remaining_nxt;
  logic [31:0]  tick_count_r, tick_count_nxt;
  logic [31:0]  last_activity_r, last_activity_nxt;

  logic        for_us;
  logic        wrq_allowed;
  logic [15:0] rrq_sent;
  logic [15:0] ack_sent;
  logic [15:0] blk_inc;

  assign for_us = (item.target_ip == server_ip_r);

  // First block of a download comes from the whole file, later ones from
  // what is left.
  assign rrq_sent = (file_length_r > {16'd0, BLOCK_BYTES}) ? BLOCK_BYTES
                                                            : file_length_r[15:0];
  assign ack_sent = (bytes_remaining_r > {16'd0, BLOCK_BYTES}) ? BLOCK_BYTES
                                                                : bytes_remaining_r[15:0];
  assign blk_inc  = expected_block_r + 16'd1;

  assign wrq_allowed = !session_lock_r || (expected_block_r == 16'd1) ||
                       ((tick_count_r - last_activity_r) > {16'd0, wrq_timeout_r});

  always_comb begin
    proto_state_nxt     = proto_state_r;
    session_lock_nxt    = session_lock_r;
    expected_block_nxt  = expected_block_r;
    client_port_nxt     = client_port_r;
    session_port_nxt    = session_port_r;
    client_mac_nxt      = client_mac_r;
    client_ip_nxt       = client_ip_r;
    store_pointer_nxt   = store_pointer_r;
    file_length_nxt     = file_length_r;
    read_pointer_nxt    = read_pointer_r;
    bytes_remaining_nxt = bytes_remaining_r;
    tick_count_nxt      = tick_count_r;
    last_activity_nxt   = last_activity_r;
    res                 = '0;

    if (step) begin
      unique case (item.command)
        CMD_TICK: begin
          tick_count_nxt = tick_count_r + 32'd1;
        end
        CMD_ARP_REQ: begin
          if (for_us) begin
            res.action   = ACT_ARP_REPLY;
            res.peer_mac = item.sender_mac;
            res.peer_ip  = item.sender_ip;
          end
        end
        CMD_ARP_REPLY: begin
        end
        CMD_UDP: begin
          if (item.header_ok && for_us) begin
            unique case (item.tftp_opcode)
              OP_RRQ: begin
                if (!session_lock_r) begin
                  last_activity_nxt = tick_count_r;
                  if (proto_state_r != ST_IDLE) begin
                    res.state_error = 1'b1;
                    proto_state_nxt = ST_IDLE;
                  end else if (file_length_r != 32'd0 &&
                               item.dest_port == SERVICE_PORT) begin
                    client_port_nxt     = item.source_port;
                    client_mac_nxt      = item.sender_mac;
                    client_ip_nxt       = item.sender_ip;
                    read_pointer_nxt    = image_base_r + {16'd0, rrq_sent};
                    bytes_remaining_nxt = file_length_r - {16'd0, rrq_sent};
                    expected_block_nxt  = 16'd1;
                    session_lock_nxt    = 1'b1;
                    proto_state_nxt     = ST_DOWNLOAD;
                    res.action          = ACT_DATA;
                    res.reply_block     = 16'd1;
                    res.peer_mac        = item.sender_mac;
                    res.peer_ip         = item.sender_ip;
                    res.peer_port       = item.source_port;
                    res.own_port        = session_port_r;
                    res.buffer_address  = image_base_r;
                    res.byte_count      = rrq_sent;
                    if (rrq_sent < BLOCK_BYTES) begin
                      res.transfer_done = DONE_DOWNLOAD;
                      proto_state_nxt   = ST_IDLE;
                      session_lock_nxt  = 1'b0;
                      session_port_nxt  = session_port_r + 16'd1;
                    end
                  end
                end
              end
              OP_WRQ: begin
                if (wrq_allowed) begin
                  last_activity_nxt = tick_count_r;
                  if (proto_state_r == ST_DOWNLOAD) begin
                    res.state_error = 1'b1;
                    proto_state_nxt = ST_IDLE;
                  end else if (item.dest_port == SERVICE_PORT) begin
                    client_port_nxt    = item.source_port;
                    client_mac_nxt     = item.sender_mac;
                    client_ip_nxt      = item.sender_ip;
                    store_pointer_nxt  = image_base_r;
                    file_length_nxt    = 32'd0;
                    expected_block_nxt = 16'd1;
                    session_lock_nxt   = 1'b1;
                    proto_state_nxt    = ST_UPLOAD;
                    res.action         = ACT_ACK;
                    res.peer_mac       = item.sender_mac;
                    res.peer_ip        = item.sender_ip;
                    res.peer_port      = item.source_port;
                    res.own_port       = session_port_r;
                  end
                end
              end
              OP_DATA: begin
                last_activity_nxt = tick_count_r;
                if (proto_state_r != ST_UPLOAD) begin
                  res.state_error = 1'b1;
                end else if (item.dest_port == session_port_r) begin
                  client_port_nxt = item.source_port;
                  res.action      = ACT_ACK;
                  res.peer_mac    = client_mac_r;
                  res.peer_ip     = client_ip_r;
                  res.peer_port   = item.source_port;
                  res.own_port    = session_port_r;
                  if (item.block_number != expected_block_r) begin
                    // stale or out of order: repeat the last ACK
                    res.reply_block = expected_block_r - 16'd1;
                  end else begin
                    res.reply_block    = expected_block_r;
                    res.buffer_address = store_pointer_r;
                    res.byte_count     = item.payload_length;
                    res.store_payload  = 1'b1;
                    store_pointer_nxt  = store_pointer_r + {16'd0, item.payload_length};
                    file_length_nxt    = file_length_r + {16'd0, item.payload_length};
                    expected_block_nxt = blk_inc;
                    if (item.payload_length < BLOCK_BYTES) begin
                      res.transfer_done  = DONE_UPLOAD;
                      expected_block_nxt = 16'd0;
                      store_pointer_nxt  = image_base_r;
                      proto_state_nxt    = ST_IDLE;
                      session_lock_nxt   = 1'b0;
                      session_port_nxt   = session_port_r + 16'd1;
                    end
                  end
                end
              end
              OP_ACK: begin
                if (proto_state_r == ST_DOWNLOAD) begin
                  last_activity_nxt = tick_count_r;
                  if (item.dest_port == session_port_r &&
                      item.block_number == expected_block_r) begin
                    expected_block_nxt  = blk_inc;
                    read_pointer_nxt    = read_pointer_r + {16'd0, ack_sent};
                    bytes_remaining_nxt = bytes_remaining_r - {16'd0, ack_sent};
                    res.action          = ACT_DATA;
                    res.reply_block     = blk_inc;
                    res.peer_mac        = client_mac_r;
                    res.peer_ip         = client_ip_r;
                    res.peer_port       = client_port_r;
                    res.own_port        = session_port_r;
                    res.buffer_address  = read_pointer_r;
                    res.byte_count      = ack_sent;
                    if (ack_sent < BLOCK_BYTES) begin
                      res.transfer_done = DONE_DOWNLOAD;
                      proto_state_nxt   = ST_IDLE;
                      session_lock_nxt  = 1'b0;
                      session_port_nxt  = session_port_r + 16'd1;
                    end
                  end
                end
              end
              OP_ERROR, OP_OACK: begin
                res.state_error = 1'b1;
                proto_state_nxt = ST_IDLE;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    res.total_length = file_length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_ip_r       <= SERVER_IP_RST;
      server_mac_r      <= '0;
      image_base_r      <= '0;
      wrq_timeout_r     <= WRQ_TIMEOUT_RST;
      first_port_r      <= FIRST_PORT_RST;
      proto_state_r     <= ST_IDLE;
      session_lock_r    <= 1'b0;
      expected_block_r  <= '0;
      client_port_r     <= '0;
      session_port_r    <= FIRST_PORT_RST;
      client_mac_r      <= '0;
      client_ip_r       <= CLIENT_IP_RST;
      store_pointer_r   <= '0;
      file_length_r     <= '0;
      read_pointer_r    <= '0;
      bytes_remaining_r <= '0;
      tick_count_r      <= '0;
      last_activity_r   <= '0;
    end else begin
      proto_state_r     <= proto_state_nxt;
      session_lock_r    <= session_lock_nxt;
      expected_block_r  <= expected_block_nxt;
      client_port_r     <= client_port_nxt;
      client_mac_r      <= client_mac_nxt;
      client_ip_r       <= client_ip_nxt;
      store_pointer_r   <= store_pointer_nxt;
      file_length_r     <= file_length_nxt;
      read_pointer_r    <= read_pointer_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      tick_count_r      <= tick_count_nxt;
      last_activity_r   <= last_activity_nxt;

      // writing the first session port also reloads the live one
      priority if (cfg.wr_en && cfg.index == CFG_FIRST_PORT) begin
        session_port_r <= cfg.wdata[15:0];
      end else begin
        session_port_r <= session_port_nxt;
      end

      if (cfg.wr_en) begin
        unique case (cfg.index)
          CFG_SERVER_IP:  server_ip_r   <= cfg.wdata[31:0];
          CFG_SERVER_MAC: server_mac_r  <= cfg.wdata[47:0];
          CFG_IMAGE_BASE: image_base_r  <= cfg.wdata[31:0];
          CFG_WRQ_TMO:    wrq_timeout_r <= cfg.wdata[15:0];
          CFG_FIRST_PORT: first_port_r  <= cfg.wdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // server_mac and first_port are held for the host; the reply path does not
  // need them beyond this point.
  logic cfg_unused;
  assign cfg_unused = ^{server_mac_r, first_port_r};

endmodule

/* rtl/tftp_server_transfer_engine.sv */
// ----------------------------------------------------------------------------
// TFTP server transfer engine
// Answers ARP for the server address and runs TFTP upload/download sessions
// from pre-parsed frames and timer ticks, one reply per transaction.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake         | payload
//   in_      | input     | in_valid/in_stall | tste_in_t  (frame or tick)
//   out_     | output    | out_valid/out_stall | tste_out_t (one reply each)
//   cfg_     | input     | cfg_wr_en         | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_stall is low; each accepted
// transaction passes the input register, then the decision logic into the
// result register, where out_valid rises with its reply.
// Reset is synchronous on rst_n; configuration and session state take their
// reset values, both stages empty. A stalled result holds the result register;
// one more transaction is taken into the input register and then in_stall rises.
// ----------------------------------------------------------------------------
module tftp_server_transfer_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tste_pkg::tste_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tste_pkg::tste_out_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [tste_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tste_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tste_pkg::*;

  logic      in_valid_r;
  tste_in_t  in_item_r;
  logic      out_valid_r;
  tste_out_t out_item_r;
  tste_out_t core_res;
  tste_cfg_t cfg;
  logic      in_fire;
  logic      advance;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  assign cfg.wr_en = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  tste_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (advance),
    .item  (in_item_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* rtl/tste_checker.sv */
// ----------------------------------------------------------------------------
// TFTP server transfer engine checker
// Port-level properties of the reply stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "tftp_server_transfer_engine_assert.svh"

module tste_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tste_pkg::tste_out_t out_data
);
  import tste_pkg::*;

  `TSTE_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "reply changed while stalled")

  // ARP replies carry no UDP part
  `TSTE_ASSERT_IMPLY(a_arp_clean, clk, rst_n, out_valid && out_data.action == ACT_ARP_REPLY, out_data.peer_port == 16'd0 && out_data.own_port == 16'd0 && !out_data.store_payload && out_data.transfer_done == DONE_NONE, "ARP reply with UDP fields")

  // dropped events send nothing
  `TSTE_ASSERT_IMPLY(a_err_silent, clk, rst_n, out_valid && out_data.state_error, out_data.action == ACT_NONE, "reply sent with state error")

  // end of a download is always a short DATA block
  `TSTE_ASSERT_IMPLY(a_dl_short, clk, rst_n, out_valid && out_data.transfer_done == DONE_DOWNLOAD, out_data.action == ACT_DATA && out_data.byte_count < BLOCK_BYTES, "download end without short block")

  // payload stores only come with an ACK
  `TSTE_ASSERT_IMPLY(a_store_ack, clk, rst_n, out_valid && out_data.store_payload, out_data.action == ACT_ACK, "store without ACK")

endmodule

bind tftp_server_transfer_engine tste_checker u_tste_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
